// ===== rtl/glbe_pkg.sv =====
package glbe_pkg;

   localparam int MAX_PEAKS = 32;
   localparam int MAX_HILLS = 32;
   localparam int MAX_STEPS = (MAX_PEAKS > MAX_HILLS) ? MAX_PEAKS : MAX_HILLS;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int COUNT_W = 6;
   localparam int DRAIN_CYCLES = 6;
   localparam int DRAIN_W = $clog2(DRAIN_CYCLES);
   localparam int ACC_W = 41;
   localparam logic [31:0] RADIUS_RESET = 32'd268435;
   localparam logic [15:0] LOG2E_Q15 = 16'd47274;

   typedef enum logic [1:0] {
      REQ_LOAD_PEAK = 2'd0,
      REQ_LOAD_HILL = 2'd1,
      REQ_EVAL      = 2'd2,
      REQ_NONE      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_PEAK_COUNT     = 2'd0,
      CSR_HILL_COUNT     = 2'd1,
      CSR_PEAK_RADIUS_SQ = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] reward;
   } peak_entry_type;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] rate;
      logic [15:0]        weight;
   } hill_entry_type;

   typedef struct packed {
      logic peak_valid;
      logic hill_valid;
   } issue_type;

   typedef struct packed {
      logic               pterm_valid;
      logic signed [21:0] pterm;
      logic               hterm_valid;
      logic [32:0]        hterm;
      logic               busy;
   } dp_status_type;

   function automatic logic [16:0] exp2_tab(input logic [4:0] k);
      logic [16:0] v;
      unique case (k)
         5'd0:  v = 17'd65536;  5'd1:  v = 17'd64132;  5'd2:  v = 17'd62757;
         5'd3:  v = 17'd61413;  5'd4:  v = 17'd60097;  5'd5:  v = 17'd58809;
         5'd6:  v = 17'd57549;  5'd7:  v = 17'd56316;  5'd8:  v = 17'd55109;
         5'd9:  v = 17'd53929;  5'd10: v = 17'd52773;  5'd11: v = 17'd51642;
         5'd12: v = 17'd50535;  5'd13: v = 17'd49452;  5'd14: v = 17'd48393;
         5'd15: v = 17'd47356;  5'd16: v = 17'd46341;  5'd17: v = 17'd45348;
         5'd18: v = 17'd44376;  5'd19: v = 17'd43425;  5'd20: v = 17'd42495;
         5'd21: v = 17'd41584;  5'd22: v = 17'd40693;  5'd23: v = 17'd39821;
         5'd24: v = 17'd38968;  5'd25: v = 17'd38133;  5'd26: v = 17'd37316;
         5'd27: v = 17'd36516;  5'd28: v = 17'd35734;  5'd29: v = 17'd34968;
         5'd30: v = 17'd34219;  5'd31: v = 17'd33486;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/glbe_req_if.sv =====
interface glbe_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [4:0]         entry_index;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] entry_scale;
   logic [15:0]        hill_weight;

   modport source (output valid, req_type, entry_index, coord_x, coord_y, entry_scale,
                   hill_weight, input ready);
   modport sink (input valid, req_type, entry_index, coord_x, coord_y, entry_scale,
                 hill_weight, output ready);
endinterface

// ===== rtl/glbe_rsp_if.sv =====
interface glbe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] landscape_value;

   modport source (output valid, landscape_value, input ready);
   modport sink (input valid, landscape_value, output ready);
endinterface

// ===== rtl/glbe_peak_cell.sv =====
module glbe_peak_cell
   import glbe_pkg::*;
(
   input  logic           clock,
   input  logic           load_en,
   input  peak_entry_type load_data,
   input  logic           shift_en,
   input  peak_entry_type next_data,
   output peak_entry_type data
);
   peak_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;
endmodule

// ===== rtl/glbe_hill_cell.sv =====
module glbe_hill_cell
   import glbe_pkg::*;
(
   input  logic           clock,
   input  logic           load_en,
   input  hill_entry_type load_data,
   input  logic           shift_en,
   input  hill_entry_type next_data,
   output hill_entry_type data
);
   hill_entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (shift_en) begin
         entry_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;
endmodule

// ===== rtl/glbe_datapath.sv =====
module glbe_datapath
   import glbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  issue_type          issue,
   input  peak_entry_type     peak,
   input  hill_entry_type     hill,
   input  logic signed [15:0] point_x,
   input  logic signed [15:0] point_y,
   input  logic [31:0]        radius_sq,
   output dp_status_type      status
);
   logic signed [16:0] pdx, pdy, hdx, hdy;
   logic signed [33:0] pdx2, pdy2, hdx2, hdy2;

   // stage 1: squares
   logic               s1_pv_ff, s1_hv_ff;
   logic [31:0]        s1_pdx2_ff, s1_pdy2_ff, s1_hdx2_ff, s1_hdy2_ff;
   logic signed [15:0] s1_reward_ff, s1_rate_ff;
   logic [15:0]        s1_weight_ff;
   // stage 2: distance, peak hit
   logic               s2_pv_ff, s2_hv_ff, s2_grow_ff;
   logic signed [21:0] s2_pterm_ff;
   logic [32:0]        s2_d_ff;
   logic [15:0]        s2_mag_ff, s2_weight_ff;
   // stage 3: rate times distance
   logic               s3_hv_ff, s3_grow_ff;
   logic [26:0]        s3_m_ff;
   logic [15:0]        s3_weight_ff;
   // stage 4: exponent of two
   logic               s4_hv_ff, s4_grow_ff;
   logic [27:0]        s4_t_ff;
   logic [15:0]        s4_weight_ff;
   // stage 5: factor
   logic               s5_hv_ff;
   logic [32:0]        s5_factor_ff, s5_factor_in;
   logic [15:0]        s5_weight_ff;
   // stage 6: term
   logic               s6_hv_ff;
   logic [32:0]        s6_hterm_ff;

   logic [32:0]        pd, hd;
   logic signed [16:0] rate_ext;
   logic [16:0]        rate_abs;
   logic [48:0]        prod_p;
   logic [42:0]        prod_t;
   logic [3:0]         n;
   logic [4:0]         k;
   logic [16:0]        tab_k, tab_neg;
   logic [48:0]        prod_w;

   assign pdx = {point_x[15], point_x} - {peak.cx[15], peak.cx};
   assign pdy = {point_y[15], point_y} - {peak.cy[15], peak.cy};
   assign hdx = {point_x[15], point_x} - {hill.cx[15], hill.cx};
   assign hdy = {point_y[15], point_y} - {hill.cy[15], hill.cy};
   assign pdx2 = pdx * pdx;
   assign pdy2 = pdy * pdy;
   assign hdx2 = hdx * hdx;
   assign hdy2 = hdy * hdy;

   assign pd = {1'b0, s1_pdx2_ff} + {1'b0, s1_pdy2_ff};
   assign hd = {1'b0, s1_hdx2_ff} + {1'b0, s1_hdy2_ff};
   assign rate_ext = {s1_rate_ff[15], s1_rate_ff};
   assign rate_abs = rate_ext[16] ? 17'(-rate_ext) : 17'(rate_ext);

   assign prod_p = 49'(s2_mag_ff) * 49'(s2_d_ff);
   assign prod_t = 43'(s3_m_ff) * 43'(LOG2E_Q15);

   assign n = s4_t_ff[19:16];
   assign k = s4_t_ff[15:11];
   assign tab_k = exp2_tab(k);
   assign tab_neg = exp2_tab(5'(~k + 5'd1));

   always_comb begin
      if (s4_t_ff[27:20] != 8'd0) begin
         s5_factor_in = s4_grow_ff ? {1'b1, 32'd0} : 33'd0;
      end else if (!s4_grow_ff) begin
         s5_factor_in = 33'(tab_k >> n);
      end else if (k == 5'd0) begin
         s5_factor_in = 33'd65536 << n;
      end else begin
         s5_factor_in = (33'(tab_neg) << 1) << n;
      end
   end

   assign prod_w = 49'(s5_weight_ff) * 49'(s5_factor_ff);

   always_ff @(posedge clock) begin
      s1_pdx2_ff   <= pdx2[31:0];
      s1_pdy2_ff   <= pdy2[31:0];
      s1_hdx2_ff   <= hdx2[31:0];
      s1_hdy2_ff   <= hdy2[31:0];
      s1_reward_ff <= peak.reward;
      s1_rate_ff   <= hill.rate;
      s1_weight_ff <= hill.weight;

      s2_pterm_ff  <= {s1_reward_ff, 6'd0};
      s2_d_ff      <= hd;
      s2_mag_ff    <= rate_abs[15:0];
      s2_grow_ff   <= s1_rate_ff[15];
      s2_weight_ff <= s1_weight_ff;

      s3_m_ff      <= prod_p[48:22];
      s3_grow_ff   <= s2_grow_ff;
      s3_weight_ff <= s2_weight_ff;

      s4_t_ff      <= prod_t[42:15];
      s4_grow_ff   <= s3_grow_ff;
      s4_weight_ff <= s3_weight_ff;

      s5_factor_ff <= s5_factor_in;
      s5_weight_ff <= s4_weight_ff;

      s6_hterm_ff  <= prod_w[48:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pv_ff <= 1'b0;
         s1_hv_ff <= 1'b0;
         s2_pv_ff <= 1'b0;
         s2_hv_ff <= 1'b0;
         s3_hv_ff <= 1'b0;
         s4_hv_ff <= 1'b0;
         s5_hv_ff <= 1'b0;
         s6_hv_ff <= 1'b0;
      end else begin
         s1_pv_ff <= issue.peak_valid;
         s1_hv_ff <= issue.hill_valid;
         s2_pv_ff <= s1_pv_ff && (pd < {1'b0, radius_sq});
         s2_hv_ff <= s1_hv_ff;
         s3_hv_ff <= s2_hv_ff;
         s4_hv_ff <= s3_hv_ff;
         s5_hv_ff <= s4_hv_ff;
         s6_hv_ff <= s5_hv_ff;
      end
   end

   assign status.pterm_valid = s2_pv_ff;
   assign status.pterm       = s2_pterm_ff;
   assign status.hterm_valid = s6_hv_ff;
   assign status.hterm       = s6_hterm_ff;
   assign status.busy        = s1_pv_ff | s1_hv_ff | s2_pv_ff | s2_hv_ff | s3_hv_ff |
                               s4_hv_ff | s5_hv_ff | s6_hv_ff;
endmodule

// ===== rtl/gaussian_bump_landscape_eval.sv =====
// Landscape evaluator over up to 32 peaks and 32 hills. Load transactions write one table
// entry and leave the block idle, so it stays ready for the next request. An evaluate
// transaction runs through the run, drain and finish states from acceptance to a result: the entry rings
// rotate one full lap, one peak and one hill cell entering the shared distance and
// exponent pipeline each cycle, then the six-stage pipeline drains. A new transaction is
// taken while a finished result still waits on the response channel.
module gaussian_bump_landscape_eval
   import glbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   glbe_req_if.sink    req_chan,
   glbe_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DRAIN_W-1:0]    drain_ff, drain_in;
   logic [COUNT_W-1:0]    peak_count_ff, hill_count_ff;
   logic [31:0]           radius_ff;
   logic signed [15:0]    x_ff, y_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_data_ff, rsp_data_in;

   logic                  accept, load_peak, load_hill, shift_peak, shift_hill;
   issue_type             issue;
   dp_status_type         status;
   peak_entry_type        peak_load, peak_data [MAX_PEAKS];
   hill_entry_type        hill_load, hill_data [MAX_HILLS];
   logic signed [31:0]    sat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign load_peak = accept && (req_code_type'(req_chan.req_type) == REQ_LOAD_PEAK) &&
                      (int'(req_chan.entry_index) < MAX_PEAKS);
   assign load_hill = accept && (req_code_type'(req_chan.req_type) == REQ_LOAD_HILL) &&
                      (int'(req_chan.entry_index) < MAX_HILLS);
   assign shift_peak = (state_ff == ST_RUN) && (int'(step_ff) < MAX_PEAKS);
   assign shift_hill = (state_ff == ST_RUN) && (int'(step_ff) < MAX_HILLS);
   assign issue.peak_valid = (state_ff == ST_RUN) && (int'(step_ff) < int'(peak_count_ff))
                             && (int'(step_ff) < MAX_PEAKS);
   assign issue.hill_valid = (state_ff == ST_RUN) && (int'(step_ff) < int'(hill_count_ff))
                             && (int'(step_ff) < MAX_HILLS);

   assign peak_load = '{cx: req_chan.coord_x, cy: req_chan.coord_y,
                        reward: req_chan.entry_scale};
   assign hill_load = '{cx: req_chan.coord_x, cy: req_chan.coord_y,
                        rate: req_chan.entry_scale, weight: req_chan.hill_weight};

   // entry rings, each cell hands its entry to the one below per step
   for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_peak
      glbe_peak_cell u_cell (
         .clock     (clock),
         .load_en   (load_peak && (int'(req_chan.entry_index) == i)),
         .load_data (peak_load),
         .shift_en  (shift_peak),
         .next_data (peak_data[(i + 1) % MAX_PEAKS]),
         .data      (peak_data[i])
      );
   end

   for (genvar i = 0; i < MAX_HILLS; i++) begin : g_hill
      glbe_hill_cell u_cell (
         .clock     (clock),
         .load_en   (load_hill && (int'(req_chan.entry_index) == i)),
         .load_data (hill_load),
         .shift_en  (shift_hill),
         .next_data (hill_data[(i + 1) % MAX_HILLS]),
         .data      (hill_data[i])
      );
   end

   glbe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .peak      (peak_data[0]),
      .hill      (hill_data[0]),
      .point_x   (x_ff),
      .point_y   (y_ff),
      .radius_sq (radius_ff),
      .status    (status)
   );

   always_comb begin
      if (acc_ff > ACC_W'(32'sh7FFFFFFF)) begin
         sat = 32'sh7FFFFFFF;
      end else if (acc_ff < -ACC_W'(33'sh080000000)) begin
         sat = 32'sh80000000;
      end else begin
         sat = acc_ff[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      acc_in       = acc_ff;
      if (status.pterm_valid) begin
         acc_in = acc_in + ACC_W'(status.pterm);
      end
      if (status.hterm_valid) begin
         acc_in = acc_in + ACC_W'(status.hterm);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_code_type'(req_chan.req_type) == REQ_EVAL)) begin
               acc_in   = '0;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (int'(step_ff) == MAX_STEPS - 1) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (int'(drain_ff) == DRAIN_CYCLES - 1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         drain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         peak_count_ff <= '0;
         hill_count_ff <= '0;
         radius_ff     <= RADIUS_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_PEAK_COUNT:     peak_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_HILL_COUNT:     hill_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_PEAK_RADIUS_SQ: radius_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (accept && (req_code_type'(req_chan.req_type) == REQ_EVAL)) begin
         x_ff <= req_chan.coord_x;
         y_ff <= req_chan.coord_y;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.landscape_value = rsp_data_ff;

   // pipeline empty whenever a new transaction can start
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.busy)
      else $error("pipeline busy in idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (int'(step_ff) < MAX_STEPS))
      else $error("step counter out of range");
endmodule
